@@ hdl/tbwt_pkg.sv @@
// Shared constants and types for the tournament best/worst tracker.
package tbwt_pkg;

   localparam int IdxW         = 10;
   localparam int CountW       = 11;
   localparam int FillW        = 3;
   localparam int SlotN        = 4;
   localparam int FieldFitW    = 32;
   localparam int FitnessBits  = 32;
   localparam int PopMax       = 1024;
   localparam int PopW         = 17;
   localparam int ReqDataW     = 48;
   localparam int RspDataW     = 48;

   localparam logic [CountW-1:0] RoundsReset = CountW'(4);

   localparam logic [FillW-1:0] FillFull = FillW'(SlotN);

   typedef enum logic [1:0] {
      SLOT_PARENT_ONE = 2'd0,
      SLOT_PARENT_TWO = 2'd1,
      SLOT_CHILD_ONE  = 2'd2,
      SLOT_CHILD_TWO  = 2'd3
   } slot_pos_type;

   typedef logic [SlotN-1:0][IdxW-1:0] slot_idx_type;

   typedef struct packed {
      logic                 dup;
      slot_idx_type         idx_next;
      logic [FillW-1:0]     fill_next;
   } slot_view_type;

endpackage

@@ hdl/tournament_best_worst_tracker_top.sv @@
// Top level of the tournament best/worst tracker with stream ports.
// A round's last contestant passes the input register, then the output register.
// Throughput: one contestant per cycle unless stalled, set by the slot update loop.
// The request side stalls only while a result waits in the output register.
// Reset (synchronous, active high) empties the slots and counters and sets the rounds
// register to four.
module tournament_best_worst_tracker_top #(
   parameter int FITNESS_BITS = tbwt_pkg::FitnessBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // contestant_index [9:0], contestant_fitness [41:10], zero fill above.
   input  logic [tbwt_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // parent_one_index [9:0], parent_two_index [19:10], child_one_index [29:20],
   // child_two_index [39:30], slots_filled [42:40], zero fill above.
   output logic [tbwt_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [tbwt_pkg::CountW-1:0]   csr_wr_data
);
   import tbwt_pkg::*;

   localparam int FitW = (FITNESS_BITS < FieldFitW) ? FITNESS_BITS : FieldFitW;

   logic                 in_valid_ff, in_valid_in;
   logic [IdxW-1:0]      in_index_ff, in_index_in;
   logic [FitW-1:0]      in_fit_ff, in_fit_in;
   logic [CountW-1:0]    rounds_ff, rounds_in;
   logic [CountW-1:0]    accepted_ff, accepted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]  rsp_data_ff, rsp_data_in;

   slot_view_type        view;
   logic                 proc_go;
   logic                 in_range;
   logic                 take;
   logic                 emit;
   logic [CountW-1:0]    count_next;
   logic [CountW-1:0]    target;

   assign proc_go    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_go;
   assign in_range   = PopW'(in_index_ff) < PopW'(PopMax);
   assign take       = proc_go && in_range && !view.dup;
   assign count_next = accepted_ff + CountW'(1);
   assign target     = (rounds_ff == '0) ? CountW'(1) : rounds_ff;
   assign emit       = take && (count_next >= target);

   tbwt_slots #(
      .FITNESS_BITS (FITNESS_BITS)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .clear      (emit),
      .cand_index (in_index_ff),
      .cand_fit   (in_fit_ff),
      .view       (view)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_index_in = in_index_ff;
      in_fit_in   = in_fit_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_index_in = req_tdata[IdxW-1:0];
         in_fit_in   = req_tdata[IdxW +: FitW];
      end
   end

   always_comb begin
      rounds_in = csr_wr_en ? csr_wr_data : rounds_ff;
      accepted_in = accepted_ff;
      if (take) begin
         accepted_in = emit ? '0 : count_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RspDataW'({view.fill_next, view.idx_next[SLOT_CHILD_TWO],
                                   view.idx_next[SLOT_CHILD_ONE],
                                   view.idx_next[SLOT_PARENT_TWO],
                                   view.idx_next[SLOT_PARENT_ONE]});
      end
   end

   always_ff @(posedge clock) begin
      in_index_ff <= in_index_in;
      in_fit_ff   <= in_fit_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rounds_ff    <= RoundsReset;
         accepted_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rounds_ff    <= rounds_in;
         accepted_ff  <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/tbwt_slots.sv @@
// Four ranked slots: duplicate check, fill and best/worst replacement.
module tbwt_slots #(
   parameter int FITNESS_BITS = tbwt_pkg::FitnessBits,
   localparam int FitW = (FITNESS_BITS < tbwt_pkg::FieldFitW) ?
                         FITNESS_BITS : tbwt_pkg::FieldFitW
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic                        clear,
   input  logic [tbwt_pkg::IdxW-1:0]   cand_index,
   input  logic [FitW-1:0]             cand_fit,
   output tbwt_pkg::slot_view_type     view
);
   import tbwt_pkg::*;

   slot_idx_type                idx_ff, idx_in;
   logic [SlotN-1:0][FitW-1:0]  fit_ff, fit_in;
   logic [FillW-1:0]            fill_ff, fill_in;
   logic [FillW-1:0]            fill_upd;
   slot_idx_type                idx_upd;
   logic [SlotN-1:0][FitW-1:0]  fit_upd;
   logic                        dup;

   always_comb begin
      dup = 1'b0;
      for (int k = 0; k < SlotN; k++) begin
         if ((FillW'(k) < fill_ff) && (idx_ff[k] == cand_index)) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      idx_upd  = idx_ff;
      fit_upd  = fit_ff;
      fill_upd = fill_ff;
      if (fill_ff < FillFull) begin
         for (int k = 0; k < SlotN; k++) begin
            if (fill_ff == FillW'(k)) begin
               idx_upd[k] = cand_index;
               fit_upd[k] = cand_fit;
            end
         end
         fill_upd = fill_ff + FillW'(1);
      end else if (fit_ff[SLOT_PARENT_ONE] < cand_fit) begin
         idx_upd[SLOT_PARENT_TWO] = idx_ff[SLOT_PARENT_ONE];
         fit_upd[SLOT_PARENT_TWO] = fit_ff[SLOT_PARENT_ONE];
         idx_upd[SLOT_PARENT_ONE] = cand_index;
         fit_upd[SLOT_PARENT_ONE] = cand_fit;
      end else if (fit_ff[SLOT_PARENT_TWO] < cand_fit) begin
         idx_upd[SLOT_PARENT_TWO] = cand_index;
         fit_upd[SLOT_PARENT_TWO] = cand_fit;
      end else if (fit_ff[SLOT_CHILD_TWO] > cand_fit) begin
         idx_upd[SLOT_CHILD_ONE] = idx_ff[SLOT_CHILD_TWO];
         fit_upd[SLOT_CHILD_ONE] = fit_ff[SLOT_CHILD_TWO];
         idx_upd[SLOT_CHILD_TWO] = cand_index;
         fit_upd[SLOT_CHILD_TWO] = cand_fit;
      end else if (fit_ff[SLOT_CHILD_ONE] > cand_fit) begin
         idx_upd[SLOT_CHILD_ONE] = cand_index;
         fit_upd[SLOT_CHILD_ONE] = cand_fit;
      end
   end

   always_comb begin
      view.dup       = dup;
      view.fill_next = fill_upd;
      for (int k = 0; k < SlotN; k++) begin
         view.idx_next[k] = (FillW'(k) < fill_upd) ? idx_upd[k] : '0;
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      fit_in  = fit_ff;
      fill_in = fill_ff;
      if (take) begin
         idx_in  = idx_upd;
         fit_in  = fit_upd;
         fill_in = clear ? '0 : fill_upd;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      fit_ff <= fit_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule
